>>> hdl/i2c_register_master_top_assert.svh
// Assertion macros for the I2C register master.
// Used by i2c_register_master_top; expects clk and arst_n in scope.
`ifndef I2C_REGISTER_MASTER_TOP_ASSERT_SVH
`define I2C_REGISTER_MASTER_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define I2CRM_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
`define I2CRM_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);
`else
`define I2CRM_ASSERT(lbl, prop, msg)
`define I2CRM_NEVER(lbl, cond, msg)
`endif
`endif

>>> hdl/i2crm_pkg.sv
// Shared types and constants for the I2C register master.
// No dependencies; imported by i2crm_engine and i2c_register_master_top.
`timescale 1ns / 1ps
package i2crm_pkg;

	localparam int CFG_IDX_W = 2;

	localparam logic [CFG_IDX_W-1:0] CFG_HALF_PERIOD = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_ACK_WAIT    = 2'd1;

	localparam logic [15:0] HALF_PERIOD_RESET = 16'd5;
	localparam logic [15:0] ACK_WAIT_RESET    = 16'd250;

	localparam logic [1:0] OP_NONE  = 2'd0;
	localparam logic [1:0] OP_WRITE = 2'd1;
	localparam logic [1:0] OP_READ  = 2'd2;

	typedef struct packed {
		logic [1:0] op;
		logic [7:0] device_addr;
		logic [7:0] reg_addr;
		logic [7:0] wr_data;
		logic       sda_in;
	} req_t;

	typedef struct packed {
		logic       scl_out;
		logic       sda_out;
		logic       busy_res;
		logic       done_res;
		logic [7:0] rd_data;
		logic       ack_timeout;
	} res_t;

	typedef struct packed {
		logic [15:0] half_period_ticks;
		logic [15:0] ack_wait_limit;
	} cfg_t;

endpackage

>>> hdl/i2c_register_master_top.sv
// Top level of the I2C register master: handshakes, configuration registers, result register.
// Depends on i2crm_pkg, i2crm_engine and i2c_register_master_top_assert.svh.
//
//   channel   direction  handshake             payload
//   req       in         req_valid/req_ready   req_t: op, addresses, data, sampled SDA
//   res       out        res_valid/res_ready   res_t: bus drive, status, read byte
//   cfg       in         cfg_valid/cfg_ready   cfg_index, cfg_data (always ready)
//
// One word is taken every cycle unless the result register is stalled; each word is one
// bus tick and gives exactly one result. A word passes from the input register to the
// result register when the sequencer steps; one state update per step sets this rate.
// Reset clears the sequencer, and restores a half period of 5 ticks and an ack wait of 250.
// While the result register is stalled, the input register holds one further word.
`timescale 1ns / 1ps
`include "i2c_register_master_top_assert.svh"
module i2c_register_master_top import i2crm_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 req_valid,
	output logic                 req_ready,
	input  req_t                 req,
	output logic                 res_valid,
	input  logic                 res_ready,
	output res_t                 res,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [15:0]          cfg_data
);

	cfg_t cfg_q;
	req_t req_s1;
	logic valid_s1;
	res_t res_s2;
	logic valid_s2;
	res_t next_res;
	logic advance;

	assign cfg_ready = 1'b1;
	assign advance   = valid_s1 && (!valid_s2 || res_ready);
	assign req_ready = !valid_s1 || advance;
	assign res_valid = valid_s2;
	assign res       = res_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.half_period_ticks <= HALF_PERIOD_RESET;
			cfg_q.ack_wait_limit    <= ACK_WAIT_RESET;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_HALF_PERIOD: cfg_q.half_period_ticks <= cfg_data;
				CFG_ACK_WAIT:    cfg_q.ack_wait_limit    <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (req_ready) begin
				valid_s1 <= req_valid;
			end
			if (advance) begin
				valid_s2 <= 1'b1;
			end else if (res_ready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req_valid && req_ready) begin
			req_s1 <= req;
		end
		if (advance) begin
			res_s2 <= next_res;
		end
	end

	i2crm_engine u_engine (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (advance),
		.item   (req_s1),
		.cfg    (cfg_q),
		.result (next_res)
	);

	`I2CRM_ASSERT(a_step_gives_word, advance |=> valid_s2, "processed word was lost")
	`I2CRM_ASSERT(a_full_stall, (valid_s1 && valid_s2 && !res_ready) |-> !req_ready, "taken when full")
	`I2CRM_NEVER(a_done_not_busy, valid_s2 && res_s2.done_res && res_s2.busy_res, "done while busy")
	`I2CRM_ASSERT(a_idle_bus, (res_valid && !res.busy_res) |-> res.scl_out && res.sda_out, "bus not freed")

endmodule

>>> hdl/i2crm_engine.sv
// Bus sequencer of the I2C register master: slot timer, bit shifter and phase control.
// Depends on i2crm_pkg. Advances one tick whenever step is high.
`timescale 1ns / 1ps
module i2crm_engine import i2crm_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic step,
	input  req_t item,
	input  cfg_t cfg,
	output res_t result
);

	localparam logic [3:0] PH_IDLE      = 4'd0;
	localparam logic [3:0] PH_RS_PREP   = 4'd1;
	localparam logic [3:0] PH_ST_A      = 4'd2;
	localparam logic [3:0] PH_ST_B      = 4'd3;
	localparam logic [3:0] PH_TX_LOW    = 4'd4;
	localparam logic [3:0] PH_TX_HIGH   = 4'd5;
	localparam logic [3:0] PH_ACK_LOW   = 4'd6;
	localparam logic [3:0] PH_ACK_HIGH  = 4'd7;
	localparam logic [3:0] PH_RX_LOW    = 4'd8;
	localparam logic [3:0] PH_RX_HIGH   = 4'd9;
	localparam logic [3:0] PH_NACK_LOW  = 4'd10;
	localparam logic [3:0] PH_NACK_HIGH = 4'd11;
	localparam logic [3:0] PH_SP_A      = 4'd12;
	localparam logic [3:0] PH_SP_B      = 4'd13;
	localparam logic [3:0] PH_SP_C      = 4'd14;

	localparam logic [1:0] BYTE_DEV  = 2'd0;
	localparam logic [1:0] BYTE_REG  = 2'd1;
	localparam logic [1:0] BYTE_LAST = 2'd2;
	localparam logic [1:0] BYTE_RX   = 2'd3;

	logic [3:0]  phase_q, n_phase;
	logic [3:0]  bit_q, n_bit, bit_inc;
	logic [7:0]  shift_q, n_shift, rx_byte;
	logic [15:0] tick_q, n_tick, tick_inc, slot_len;
	logic [15:0] wait_q, n_wait;
	logic        is_read_q, n_is_read;
	logic [7:0]  dev_q, n_dev, reg_q, n_reg, data_q, n_data;
	logic [7:0]  rd_q, n_rd;
	logic        to_q, n_to;
	logic [1:0]  idx_q, n_idx;
	logic        slot_end;

	always_comb begin
		n_phase   = phase_q;
		n_bit     = bit_q;
		n_shift   = shift_q;
		n_tick    = tick_q;
		n_wait    = wait_q;
		n_is_read = is_read_q;
		n_dev     = dev_q;
		n_reg     = reg_q;
		n_data    = data_q;
		n_rd      = rd_q;
		n_to      = to_q;
		n_idx     = idx_q;
		slot_end  = 1'b0;
		slot_len  = (cfg.half_period_ticks == 16'd0) ? 16'd1 : cfg.half_period_ticks;
		tick_inc  = tick_q + 16'd1;
		bit_inc   = bit_q + 4'd1;
		rx_byte   = {shift_q[6:0], item.sda_in};

		if (phase_q == PH_IDLE) begin
			if (item.op == OP_WRITE || item.op == OP_READ) begin
				n_is_read = (item.op == OP_READ);
				n_dev     = item.device_addr;
				n_reg     = item.reg_addr;
				n_data    = item.wr_data;
				n_to      = 1'b0;
				n_idx     = BYTE_DEV;
				n_bit     = 4'd0;
				n_shift   = 8'd0;
				n_wait    = 16'd0;
				n_tick    = 16'd0;
				n_phase   = PH_ST_A;
			end
		end else begin
			n_tick = tick_inc;
			if (tick_inc >= slot_len) begin
				n_tick   = 16'd0;
				slot_end = 1'b1;
				case (phase_q)
					PH_RS_PREP: n_phase = PH_ST_A;
					PH_ST_A:    n_phase = PH_ST_B;
					PH_ST_B: begin
						// The first start carries the write address, the repeated one the read.
						n_shift = {dev_q[7:1], (idx_q != BYTE_DEV)};
						n_bit   = 4'd0;
						n_phase = PH_TX_LOW;
					end
					PH_TX_LOW: n_phase = PH_TX_HIGH;
					PH_TX_HIGH: begin
						n_shift = {shift_q[6:0], 1'b0};
						n_bit   = bit_inc;
						n_phase = (bit_inc >= 4'd8) ? PH_ACK_LOW : PH_TX_LOW;
					end
					PH_ACK_LOW: begin
						n_wait  = 16'd0;
						n_phase = PH_ACK_HIGH;
					end
					PH_ACK_HIGH: begin
						if (item.sda_in && (wait_q < cfg.ack_wait_limit)) begin
							// No acknowledge yet: hold SCL high for another half period.
							n_wait = wait_q + 16'd1;
						end else begin
							if (item.sda_in) begin
								n_to = 1'b1;
							end
							case (idx_q)
								BYTE_DEV: begin
									n_idx   = BYTE_REG;
									n_shift = reg_q;
									n_bit   = 4'd0;
									n_phase = PH_TX_LOW;
								end
								BYTE_REG: begin
									n_idx = BYTE_LAST;
									if (is_read_q) begin
										n_phase = PH_RS_PREP;
									end else begin
										n_shift = data_q;
										n_bit   = 4'd0;
										n_phase = PH_TX_LOW;
									end
								end
								default: begin
									n_idx = BYTE_RX;
									if (is_read_q) begin
										n_shift = 8'd0;
										n_bit   = 4'd0;
										n_phase = PH_RX_LOW;
									end else begin
										n_phase = PH_SP_A;
									end
								end
							endcase
						end
					end
					PH_RX_LOW: n_phase = PH_RX_HIGH;
					PH_RX_HIGH: begin
						n_shift = rx_byte;
						n_bit   = bit_inc;
						if (bit_inc >= 4'd8) begin
							n_rd    = rx_byte;
							n_phase = PH_NACK_LOW;
						end else begin
							n_phase = PH_RX_LOW;
						end
					end
					PH_NACK_LOW:  n_phase = PH_NACK_HIGH;
					PH_NACK_HIGH: n_phase = PH_SP_A;
					PH_SP_A:      n_phase = PH_SP_B;
					PH_SP_B:      n_phase = PH_SP_C;
					default:      n_phase = PH_IDLE;
				endcase
			end
		end
	end

	// The word reports the bus drive as it stands after this tick.
	always_comb begin
		result.busy_res    = (n_phase != PH_IDLE);
		result.done_res    = slot_end && (n_phase == PH_IDLE);
		result.rd_data     = n_rd;
		result.ack_timeout = n_to;
		case (n_phase)
			PH_RS_PREP, PH_ACK_LOW, PH_RX_LOW, PH_NACK_LOW: begin
				result.scl_out = 1'b0;
				result.sda_out = 1'b1;
			end
			PH_ST_B, PH_SP_B: begin
				result.scl_out = 1'b1;
				result.sda_out = 1'b0;
			end
			PH_TX_LOW: begin
				result.scl_out = 1'b0;
				result.sda_out = n_shift[7];
			end
			PH_TX_HIGH: begin
				result.scl_out = 1'b1;
				result.sda_out = n_shift[7];
			end
			PH_SP_A: begin
				result.scl_out = 1'b0;
				result.sda_out = 1'b0;
			end
			default: begin
				result.scl_out = 1'b1;
				result.sda_out = 1'b1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_IDLE;
			bit_q     <= 4'd0;
			shift_q   <= 8'd0;
			tick_q    <= 16'd0;
			wait_q    <= 16'd0;
			is_read_q <= 1'b0;
			rd_q      <= 8'd0;
			to_q      <= 1'b0;
			idx_q     <= BYTE_DEV;
		end else if (step) begin
			phase_q   <= n_phase;
			bit_q     <= n_bit;
			shift_q   <= n_shift;
			tick_q    <= n_tick;
			wait_q    <= n_wait;
			is_read_q <= n_is_read;
			rd_q      <= n_rd;
			to_q      <= n_to;
			idx_q     <= n_idx;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			dev_q  <= n_dev;
			reg_q  <= n_reg;
			data_q <= n_data;
		end
	end

endmodule
